// ===== hw/rtl/frsp_pkg.sv =====
// shared types and constants for the fastx record stream parser
package frsp_pkg;

	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_LF   = 8'h0A;

	localparam int unsigned IDX_W = 32;
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	typedef enum logic [1:0] {
		ROLE_SKIP = 2'd0,
		ROLE_HEAD = 2'd1,
		ROLE_SEQ  = 2'd2,
		ROLE_QUAL = 2'd3
	} role_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	typedef enum logic [7:0] {
		ST_FIRST     = 8'b0000_0001,
		ST_SEEK      = 8'b0000_0010,
		ST_SKIP      = 8'b0000_0100,
		ST_HEAD      = 8'b0000_1000,
		ST_SEQ_START = 8'b0001_0000,
		ST_SEQ_LINE  = 8'b0010_0000,
		ST_PLUS      = 8'b0100_0000,
		ST_QUAL      = 8'b1000_0000
	} parse_state_t;

	typedef struct packed {
		role_t            role;
		logic [7:0]       char_out;
		logic             record_start;
		logic             record_end;
		logic             closed_is_fastq;
		logic [IDX_W-1:0] record_index;
		logic             mate;
		logic             format_error;
	} result_t;

endpackage

// ===== hw/rtl/frsp_fsm.sv =====
// per-byte parse state machine with record counter and mate tracking
module frsp_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             interleaved,
	input  logic             kind,
	input  logic [7:0]       char_in,
	output frsp_pkg::result_t res
);
	import frsp_pkg::*;

	parse_state_t     state_q, state_d;
	logic [IDX_W-1:0] count_q, count_d;
	logic             mate_q, mate_d;
	logic             open_q, open_d;
	logic             fastq_q, fastq_d;

	logic             marker;
	logic             do_open;
	logic             pair_second;

	assign marker      = (char_in == CH_GT) || (char_in == CH_AT);
	assign pair_second = interleaved && (count_q != '0) && !mate_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		mate_d  = mate_q;
		open_d  = open_q;
		fastq_d = fastq_q;
		do_open = 1'b0;

		res.role            = ROLE_SKIP;
		res.char_out        = char_in;
		res.record_start    = 1'b0;
		res.record_end      = 1'b0;
		res.closed_is_fastq = 1'b0;
		res.format_error    = 1'b0;

		if (kind == KIND_EOS) begin
			res.char_out        = 8'd0;
			res.record_end      = open_q;
			res.closed_is_fastq = open_q & fastq_q;
		end else begin
			unique case (state_q)
				ST_FIRST, ST_SEEK: begin
					if (marker) begin
						do_open = 1'b1;
					end else begin
						res.format_error = (state_q == ST_FIRST);
						state_d = (char_in == CH_LF) ? ST_SEEK : ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (char_in == CH_LF) state_d = ST_SEEK;
				end
				ST_HEAD: begin
					if (char_in == CH_LF) state_d = ST_SEQ_START;
					else res.role = ROLE_HEAD;
				end
				ST_SEQ_START: begin
					unique if (char_in == CH_GT) begin
						do_open = 1'b1;
					end else if (char_in == CH_PLUS) begin
						fastq_d = 1'b1;
						state_d = ST_PLUS;
					end else if (char_in == CH_LF) begin
						// empty sequence line is dropped
						state_d = ST_SEQ_START;
					end else begin
						res.role = ROLE_SEQ;
						state_d  = ST_SEQ_LINE;
					end
				end
				ST_SEQ_LINE: begin
					if (char_in == CH_LF) state_d = ST_SEQ_START;
					else res.role = ROLE_SEQ;
				end
				ST_PLUS: begin
					if (char_in == CH_LF) state_d = ST_QUAL;
				end
				ST_QUAL: begin
					if (char_in == CH_LF) state_d = ST_SEEK;
					else res.role = ROLE_QUAL;
				end
				default: state_d = ST_SEEK;
			endcase

			if (do_open) begin
				res.record_start    = 1'b1;
				res.record_end      = open_q;
				res.closed_is_fastq = open_q & fastq_q;
				if (pair_second) begin
					mate_d = 1'b1;
				end else begin
					if (count_q != IDX_MAX) count_d = count_q + 1'b1;
					mate_d = 1'b0;
				end
				open_d  = 1'b1;
				fastq_d = 1'b0;
				state_d = ST_HEAD;
			end
		end

		// index and mate reflect the update made by this byte
		res.record_index = (kind == KIND_EOS) ? count_q : count_d;
		res.mate         = (kind == KIND_EOS) ? mate_q : mate_d;

		if (kind == KIND_EOS) begin
			state_d = ST_FIRST;
			count_d = '0;
			mate_d  = 1'b0;
			open_d  = 1'b0;
			fastq_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIRST;
			count_q <= '0;
			mate_q  <= 1'b0;
			open_q  <= 1'b0;
			fastq_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			count_q <= count_d;
			mate_q  <= mate_d;
			open_q  <= open_d;
			fastq_q <= fastq_d;
		end
	end

endmodule

// ===== hw/rtl/fastx_record_stream_parser.sv =====
// top level of the fastx record stream parser
// Usage: the input channel (in_valid/in_ready) takes one word per cycle
// unless stalled: kind selects a text byte (0) or an end of stream marker
// (1), char_in is the byte. Every accepted word gives exactly one result
// word on the output channel (out_valid/out_ready) with the byte role,
// record start/end flags, fastq flag of the closed record, the one-based
// record index, mate bit and a format error flag for a bad first byte.
// The result appears in the cycle after the word is accepted; the parse
// step is a small state machine between the input handshake and the
// output register. Throughput: one word per cycle unless the output stalls.
// The config channel (cfg_valid/cfg_ready, cfg_data) is always ready and
// writes the interleaved pairs bit; it is to be written while the block is
// idle, which the block does not enforce. Reset: arst_n clears the parse
// state, record counter, mate bit, the config bit and the output valid flag.
// Stall: while out_ready is low a held result keeps in_ready low; a new
// word is taken in the same cycle the held result is taken.
// An end of stream marker closes the open record and returns the parser
// to its reset state, ready for a new stream.
module fastx_record_stream_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [7:0]                char_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                role,
	output logic [7:0]                char_out,
	output logic                      record_start,
	output logic                      record_end,
	output logic                      closed_is_fastq,
	output logic [frsp_pkg::IDX_W-1:0] record_index,
	output logic                      mate,
	output logic                      format_error
);
	import frsp_pkg::*;

	logic    interleaved_q;
	logic    out_valid_q;
	result_t res;
	result_t res_q;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interleaved_q <= 1'b0;
		end else if (cfg_valid) begin
			interleaved_q <= cfg_data;
		end
	end

	frsp_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.interleaved (interleaved_q),
		.kind        (kind),
		.char_in     (char_in),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result word, loaded on each accepted input word
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign role            = res_q.role;
	assign char_out        = res_q.char_out;
	assign record_start    = res_q.record_start;
	assign record_end      = res_q.record_end;
	assign closed_is_fastq = res_q.closed_is_fastq;
	assign record_index    = res_q.record_index;
	assign mate            = res_q.mate;
	assign format_error    = res_q.format_error;

endmodule

// ===== dv/tb_fastx_record_stream_parser.sv =====
// testbench for the fastx record stream parser: byte tagging checked against a scoreboard
`timescale 1ns / 1ps

import frsp_pkg::*;

class tag_tracker;
	result_t      tags_due[$];
	parse_state_t pstate = ST_FIRST;
	logic [IDX_W-1:0] rec_count = '0;
	logic mate_bit = 1'b0;
	logic rec_open = 1'b0;
	logic saw_plus = 1'b0;
	logic pairs = 1'b0;
	int errors = 0;
	int reported = 0;
	int checked = 0;
	int starts = 0;
	int fastq_closed = 0;
	int ferrs = 0;
	int eos_seen = 0;
	int second_mates = 0;

	function int pending();
		return tags_due.size();
	endfunction

	// a marker opened a record: close the previous one and step index or mate
	function void open_rec(output logic re, output logic fq);
		re = rec_open;
		fq = rec_open ? saw_plus : 1'b0;
		if (pairs && rec_count != '0 && !mate_bit) begin
			mate_bit = 1'b1;
		end else begin
			if (rec_count != IDX_MAX)
				rec_count = rec_count + 1'b1;
			mate_bit = 1'b0;
		end
		rec_open = 1'b1;
		saw_plus = 1'b0;
		pstate = ST_HEAD;
	endfunction

	function result_t tag_byte(logic k, logic [7:0] c);
		result_t r;
		logic marker;
		logic re;
		logic fq;
		r = '0;
		r.role = ROLE_SKIP;
		marker = (c == CH_GT || c == CH_AT);
		if (k == KIND_EOS) begin
			r.record_end = rec_open;
			r.closed_is_fastq = rec_open ? saw_plus : 1'b0;
			r.record_index = rec_count;
			r.mate = mate_bit;
			pstate = ST_FIRST;
			rec_count = '0;
			mate_bit = 1'b0;
			rec_open = 1'b0;
			saw_plus = 1'b0;
			eos_seen++;
		end else begin
			r.char_out = c;
			case (pstate)
				ST_FIRST, ST_SEEK: begin
					if (marker) begin
						r.record_start = 1'b1;
						open_rec(re, fq);
						r.record_end = re;
						r.closed_is_fastq = fq;
					end else begin
						if (pstate == ST_FIRST)
							r.format_error = 1'b1;
						pstate = (c == CH_LF) ? ST_SEEK : ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (c == CH_LF)
						pstate = ST_SEEK;
				end
				ST_HEAD: begin
					if (c == CH_LF)
						pstate = ST_SEQ_START;
					else
						r.role = ROLE_HEAD;
				end
				ST_SEQ_START: begin
					// only '>' opens a record here, '@' is sequence data
					if (c == CH_GT) begin
						r.record_start = 1'b1;
						open_rec(re, fq);
						r.record_end = re;
						r.closed_is_fastq = fq;
					end else if (c == CH_PLUS) begin
						saw_plus = 1'b1;
						pstate = ST_PLUS;
					end else if (c != CH_LF) begin
						r.role = ROLE_SEQ;
						pstate = ST_SEQ_LINE;
					end
				end
				ST_SEQ_LINE: begin
					if (c == CH_LF)
						pstate = ST_SEQ_START;
					else
						r.role = ROLE_SEQ;
				end
				ST_PLUS: begin
					if (c == CH_LF)
						pstate = ST_QUAL;
				end
				ST_QUAL: begin
					if (c == CH_LF)
						pstate = ST_SEEK;
					else
						r.role = ROLE_QUAL;
				end
				default: begin
					pstate = ST_SEEK;
				end
			endcase
			r.record_index = rec_count;
			r.mate = mate_bit;
		end
		if (r.record_start)
			starts++;
		if (r.record_start && r.mate)
			second_mates++;
		if (r.closed_is_fastq)
			fastq_closed++;
		if (r.format_error)
			ferrs++;
		return r;
	endfunction

	function void note_word(logic k, logic [7:0] c);
		tags_due = {tags_due, tag_byte(k, c)};
	endfunction

	function string show(result_t r);
		return $sformatf("role=%0d char=%02h start=%b end=%b fq=%b idx=%0d mate=%b ferr=%b",
			r.role, r.char_out, r.record_start, r.record_end, r.closed_is_fastq,
			r.record_index, r.mate, r.format_error);
	endfunction

	function void complain(string msg);
		errors++;
		if (reported < 10) begin
			reported++;
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	function void check_tag(result_t got);
		result_t want;
		string bad;
		if (tags_due.size() == 0) begin
			complain({"result word with nothing expected: ", show(got)});
			return;
		end
		want = tags_due.pop_front();
		checked++;
		bad = "";
		if (got.role !== want.role) bad = {bad, " role"};
		if (got.char_out !== want.char_out) bad = {bad, " char_out"};
		if (got.record_start !== want.record_start) bad = {bad, " record_start"};
		if (got.record_end !== want.record_end) bad = {bad, " record_end"};
		if (got.closed_is_fastq !== want.closed_is_fastq) bad = {bad, " closed_is_fastq"};
		if (got.record_index !== want.record_index) bad = {bad, " record_index"};
		if (got.mate !== want.mate) bad = {bad, " mate"};
		if (got.format_error !== want.format_error) bad = {bad, " format_error"};
		if (bad != "")
			complain($sformatf("word %0d mismatch on%s\n  expected %s\n  actual   %s",
				checked, bad, show(want), show(got)));
	endfunction
endclass

module tb_fastx_record_stream_parser;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int WORDS_PER_SUB = 250;

	typedef enum int { TXT_HDR, TXT_BASES, TXT_QUAL } text_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [7:0] char_in;
	logic out_valid;
	logic out_ready;
	logic [1:0] role;
	logic [7:0] char_out;
	logic record_start;
	logic record_end;
	logic closed_is_fastq;
	logic [IDX_W-1:0] record_index;
	logic mate;
	logic format_error;

	tag_tracker sb;
	result_t seen_tag;
	int tx_idle = 0;
	int rx_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int words_sent = 0;
	int cfg_writes = 0;
	int quiet = 0;

	fastx_record_stream_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.role(role),
		.char_out(char_out),
		.record_start(record_start),
		.record_end(record_end),
		.closed_is_fastq(closed_is_fastq),
		.record_index(record_index),
		.mate(mate),
		.format_error(format_error)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_tag.role = role_t'(role);
			seen_tag.char_out = char_out;
			seen_tag.record_start = record_start;
			seen_tag.record_end = record_end;
			seen_tag.closed_is_fastq = closed_is_fastq;
			seen_tag.record_index = record_index;
			seen_tag.mate = mate;
			seen_tag.format_error = format_error;
			sb.check_tag(seen_tag);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d words still expected",
					quiet, sb.pending());
				$display("tb_fastx_record_stream_parser: done, errors");
				$finish;
			end
		end
	end

	task automatic send_word(input logic k, input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		char_in = c;
		do @(posedge clk); while (!in_ready);
		sb.note_word(k, c);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(KIND_DATA, s[i]);
	endtask

	task automatic send_lf();
		send_word(KIND_DATA, CH_LF);
	endtask

	task automatic send_eos();
		// char_in is don't-care here, so let it toggle
		send_word(KIND_EOS, 8'($urandom_range(255)));
	endtask

	task automatic send_field(input text_kind_t tk, input int len);
		string bases;
		logic [7:0] v;
		bases = "ACGTNacgtn";
		for (int i = 0; i < len; i++) begin
			case (tk)
				TXT_HDR: begin
					v = 8'($urandom_range(255));
					if (v == CH_LF)
						v = 8'h20;
				end
				TXT_BASES: v = bases[$urandom_range(9)];
				default: v = 8'($urandom_range(126, 33));
			endcase
			send_word(KIND_DATA, v);
		end
	endtask

	// one random piece of stream: mostly well formed records, some junk
	task automatic emit_chunk();
		int r;
		int u;
		r = $urandom_range(99);
		if (r < 45) begin
			send_word(KIND_DATA, CH_GT);
			send_field(TXT_HDR, $urandom_range(6));
			send_lf();
			repeat ($urandom_range(3)) begin
				u = $urandom_range(99);
				if (u < 15) begin
					send_lf();
				end else begin
					if (u < 25)
						send_word(KIND_DATA, CH_AT);
					send_field(TXT_BASES, $urandom_range(8, 1));
					send_lf();
				end
			end
		end else if (r < 80) begin
			send_word(KIND_DATA, CH_AT);
			send_field(TXT_HDR, $urandom_range(6));
			send_lf();
			send_field(TXT_BASES, $urandom_range(8, 1));
			send_lf();
			send_word(KIND_DATA, CH_PLUS);
			if ($urandom_range(1))
				send_field(TXT_HDR, $urandom_range(4, 1));
			send_lf();
			send_field(TXT_QUAL, $urandom_range(8, 1));
			if ($urandom_range(9) != 0)
				send_lf();
		end else if (r < 87) begin
			send_field(TXT_HDR, $urandom_range(6, 1));
			send_lf();
		end else if (r < 92) begin
			repeat ($urandom_range(3, 1)) send_lf();
		end else if (r < 97) begin
			repeat ($urandom_range(6, 1)) send_word(KIND_DATA, 8'($urandom_range(255)));
		end else begin
			send_eos();
		end
	endtask

	// sender pause: wait for every expected result, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_pairs(input logic v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.pairs = v;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		kind = KIND_DATA;
		char_in = 8'h00;
		out_ready = 1'b0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle = 26;
		rx_idle = 71;
		// newline as bad first byte, a garbage line, then an empty line while seeking
		send_lf();
		send_text("q\n");
		send_lf();
		send_word(KIND_DATA, CH_GT);
		send_word(KIND_DATA, 8'h00);
		send_word(KIND_DATA, 8'hFF);
		send_text("\nAC\n\n@G\n+\nII\n@\n>");
		send_eos();
		send_eos();
		send_text("x\n");
		wait_idle();

		// pairs: three records, then pairing switched off mid pair
		write_pairs(1'b1);
		send_text(">\n>\n>\n");
		wait_idle();
		write_pairs(1'b0);
		send_text(">\n");
		wait_idle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle = 26;
					rx_idle = 71;
				end
				1: begin
					tx_idle = 71;
					rx_idle = 26;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			for (int sub = 0; sub < 2; sub++) begin
				write_pairs(sub == 0);
				if (phase == 2 && sub == 0)
					hold_req++;
				while (words_sent < 40 + (phase * 2 + sub + 1) * WORDS_PER_SUB)
					emit_chunk();
				wait_idle();
			end
		end

		repeat (5) @(posedge clk);
		if (sb.pending() != 0)
			sb.complain($sformatf("%0d expected words never arrived", sb.pending()));
		$display("covered %0d words (%0d checked), %0d records opened, %0d second mates",
			words_sent, sb.checked, sb.starts, sb.second_mates);
		$display("fastq records closed %0d, format errors %0d, end of stream %0d, %0d cfg writes",
			sb.fastq_closed, sb.ferrs, sb.eos_seen, cfg_writes);
		if (sb.errors == 0) begin
			$display("tb_fastx_record_stream_parser: done, clean");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("tb_fastx_record_stream_parser: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/frsp_pkg.sv
hw/rtl/frsp_fsm.sv
hw/rtl/fastx_record_stream_parser.sv
dv/tb_fastx_record_stream_parser.sv
